// File: src/blsi_pkg.sv
// ----------------------------------------------------------------------------
// blsi_pkg
// Shared constants and types for the box / line-segment intersection test.
// ----------------------------------------------------------------------------
package blsi_pkg;

    // Default coordinate width: signed 24.8 fixed point.
    localparam int COORD_WIDTH_DEF = 32;

    // Outcome of the comparison-only rules, settled before any product is formed.
    typedef struct packed {
        logic done;  // answer is known without the cross products
        logic hit;   // that answer
    } t_early;

endpackage

// File: src/blsi_if.sv
// ----------------------------------------------------------------------------
// blsi_in_if / blsi_out_if
// Valid/ready channels carrying one box and segment, and one hit flag.
// ----------------------------------------------------------------------------
interface blsi_in_if #(
    parameter int COORD_WIDTH = blsi_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] box_left;
    logic signed [COORD_WIDTH-1:0] box_top;
    logic signed [COORD_WIDTH-1:0] box_right;
    logic signed [COORD_WIDTH-1:0] box_bottom;
    logic signed [COORD_WIDTH-1:0] seg_start_x;
    logic signed [COORD_WIDTH-1:0] seg_start_y;
    logic signed [COORD_WIDTH-1:0] seg_end_x;
    logic signed [COORD_WIDTH-1:0] seg_end_y;

    modport source (
        output valid, box_left, box_top, box_right, box_bottom,
               seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        input  ready
    );
    modport sink (
        input  valid, box_left, box_top, box_right, box_bottom,
               seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        output ready
    );
endinterface

interface blsi_out_if;
    logic valid;
    logic ready;
    logic hits_box;

    modport source (output valid, hits_box, input ready);
    modport sink (input valid, hits_box, output ready);
endinterface

// File: src/blsi_setup.sv
// ----------------------------------------------------------------------------
// blsi_setup
// Containment and per-axis range checks; registers the entry and exit
// distances and segment lengths for the cross-product stage.
// ----------------------------------------------------------------------------
module blsi_setup #(
    parameter int COORD_WIDTH = blsi_pkg::COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_bx0,
    input  logic signed [COORD_WIDTH-1:0] i_by0,
    input  logic signed [COORD_WIDTH-1:0] i_bx1,
    input  logic signed [COORD_WIDTH-1:0] i_by1,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_ex,
    input  logic signed [COORD_WIDTH-1:0] i_ey,
    input  logic                          i_ready,
    output logic                          o_valid,
    output blsi_pkg::t_early              o_early,
    output logic signed [DW-1:0]          o_t1,
    output logic signed [DW-1:0]          o_t2,
    output logic signed [DW-1:0]          o_t3,
    output logic signed [DW-1:0]          o_t4,
    output logic signed [DW-1:0]          o_xl,
    output logic signed [DW-1:0]          o_yl
);

    logic signed [DW-1:0] bx0, by0, bx1, by1, ax, ay, ex, ey;
    logic signed [DW-1:0] xd, yd;
    logic                 x_zero, y_zero, x_neg, y_neg;
    logic                 x_miss, y_miss, in_box;
    blsi_pkg::t_early     n_early;
    logic signed [DW-1:0] n_t1, n_t2, n_t3, n_t4, n_xl, n_yl;

    logic                 r_valid;
    blsi_pkg::t_early     r_early;
    logic signed [DW-1:0] r_t1, r_t2, r_t3, r_t4, r_xl, r_yl;

    assign bx0 = DW'(i_bx0);
    assign by0 = DW'(i_by0);
    assign bx1 = DW'(i_bx1);
    assign by1 = DW'(i_by1);
    assign ax  = DW'(i_ax);
    assign ay  = DW'(i_ay);
    assign ex  = DW'(i_ex);
    assign ey  = DW'(i_ey);

    always_comb begin
        in_box = ((ax >= bx0) && (ax <= bx1) && (ay >= by0) && (ay <= by1)) ||
                 ((ex >= bx0) && (ex <= bx1) && (ey >= by0) && (ey <= by1));

        xd     = ex - ax;
        yd     = ey - ay;
        x_zero = (xd == '0);
        y_zero = (yd == '0);
        x_neg  = xd[DW-1];
        y_neg  = yd[DW-1];

        // Distances are taken along the direction of travel on each axis.
        if (x_neg) begin
            n_t1 = ax - bx1;
            n_t2 = ax - bx0;
            n_xl = -xd;
        end else begin
            n_t1 = bx0 - ax;
            n_t2 = bx1 - ax;
            n_xl = xd;
        end
        if (y_neg) begin
            n_t3 = ay - by1;
            n_t4 = ay - by0;
            n_yl = -yd;
        end else begin
            n_t3 = by0 - ay;
            n_t4 = by1 - ay;
            n_yl = yd;
        end

        // A zero-length axis only needs the fixed coordinate inside the span.
        if (x_zero) begin
            x_miss = (ax < bx0) || (ax > bx1);
        end else begin
            x_miss = ((n_t1 < 0) || (n_t1 > n_xl)) && ((n_t2 < 0) || (n_t2 > n_xl));
        end
        if (y_zero) begin
            y_miss = (ay < by0) || (ay > by1);
        end else begin
            y_miss = ((n_t3 < 0) || (n_t3 > n_yl)) && ((n_t4 < 0) || (n_t4 > n_yl));
        end

        if (in_box) begin
            n_early = '{done: 1'b1, hit: 1'b1};
        end else if (x_miss || y_miss) begin
            n_early = '{done: 1'b1, hit: 1'b0};
        end else if (x_zero || y_zero) begin
            n_early = '{done: 1'b1, hit: 1'b1};
        end else begin
            n_early = '{done: 1'b0, hit: 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_early <= n_early;
            r_t1    <= n_t1;
            r_t2    <= n_t2;
            r_t3    <= n_t3;
            r_t4    <= n_t4;
            r_xl    <= n_xl;
            r_yl    <= n_yl;
        end
    end

    assign o_valid = r_valid;
    assign o_early = r_early;
    assign o_t1    = r_t1;
    assign o_t2    = r_t2;
    assign o_t3    = r_t3;
    assign o_t4    = r_t4;
    assign o_xl    = r_xl;
    assign o_yl    = r_yl;

endmodule

// File: src/blsi_prod.sv
// ----------------------------------------------------------------------------
// blsi_prod
// Forms the four exact cross products of distances and axis lengths.
// ----------------------------------------------------------------------------
module blsi_prod #(
    parameter int COORD_WIDTH = blsi_pkg::COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 1,
    localparam int PW = 2 * DW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  blsi_pkg::t_early     i_early,
    input  logic signed [DW-1:0] i_t1,
    input  logic signed [DW-1:0] i_t2,
    input  logic signed [DW-1:0] i_t3,
    input  logic signed [DW-1:0] i_t4,
    input  logic signed [DW-1:0] i_xl,
    input  logic signed [DW-1:0] i_yl,
    input  logic                 i_ready,
    output logic                 o_valid,
    output blsi_pkg::t_early     o_early,
    output logic signed [PW-1:0] o_p1,
    output logic signed [PW-1:0] o_p2,
    output logic signed [PW-1:0] o_p3,
    output logic signed [PW-1:0] o_p4
);

    logic                 r_valid;
    blsi_pkg::t_early     r_early;
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [PW-1:0] n_p1, n_p2, n_p3, n_p4;

    // Lengths are non-negative, so a signed compare of these products
    // orders them exactly.
    assign n_p1 = PW'(i_t1) * PW'(i_yl);
    assign n_p2 = PW'(i_t4) * PW'(i_xl);
    assign n_p3 = PW'(i_t3) * PW'(i_xl);
    assign n_p4 = PW'(i_t2) * PW'(i_yl);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_early <= i_early;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_p4    <= n_p4;
        end
    end

    assign o_valid = r_valid;
    assign o_early = r_early;
    assign o_p1    = r_p1;
    assign o_p2    = r_p2;
    assign o_p3    = r_p3;
    assign o_p4    = r_p4;

endmodule

// File: src/box_line_segment_intersect.sv
// ----------------------------------------------------------------------------
// box_line_segment_intersect
// Tests whether a line segment touches an axis-aligned box, one test per
// clock while no stage is stalled, in signed fixed-point coordinates.
// ----------------------------------------------------------------------------
//
//   Port     Dir  Handshake      Payload
//   i_in     in   valid/ready    box_left, box_top, box_right, box_bottom,
//                                seg_start_x, seg_start_y, seg_end_x, seg_end_y
//   o_out    out  valid/ready    hits_box
//
// A new item is taken every cycle while no stage is stalled; its result is
// offered once the item has passed the input register, then the range checks,
// the product registers and the result register.
// Each stage holds its item only while the next stage is full and stalled,
// so empty stages keep accepting while a result waits on o_out.
// Reset clears the valid flags only; no item is in flight afterwards.
//
module box_line_segment_intersect #(
    parameter int COORD_WIDTH = blsi_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blsi_in_if.sink    i_in,
    blsi_out_if.source o_out
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                          r_in_valid;
    logic signed [COORD_WIDTH-1:0] r_bx0, r_by0, r_bx1, r_by1;
    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_ex, r_ey;

    logic                 setup_ready, setup_valid;
    blsi_pkg::t_early     setup_early;
    logic signed [DW-1:0] t1, t2, t3, t4, xl, yl;

    logic                 prod_ready, prod_valid;
    blsi_pkg::t_early     prod_early;
    logic signed [PW-1:0] p1, p2, p3, p4;

    logic r_out_valid, r_hit, n_hit, out_ready;

    // Input register.
    assign i_in.ready = !r_in_valid || setup_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_bx0 <= i_in.box_left;
            r_by0 <= i_in.box_top;
            r_bx1 <= i_in.box_right;
            r_by1 <= i_in.box_bottom;
            r_ax  <= i_in.seg_start_x;
            r_ay  <= i_in.seg_start_y;
            r_ex  <= i_in.seg_end_x;
            r_ey  <= i_in.seg_end_y;
        end
    end

    blsi_setup #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (setup_ready),
        .i_bx0   (r_bx0),
        .i_by0   (r_by0),
        .i_bx1   (r_bx1),
        .i_by1   (r_by1),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_ex    (r_ex),
        .i_ey    (r_ey),
        .i_ready (prod_ready),
        .o_valid (setup_valid),
        .o_early (setup_early),
        .o_t1    (t1),
        .o_t2    (t2),
        .o_t3    (t3),
        .o_t4    (t4),
        .o_xl    (xl),
        .o_yl    (yl)
    );

    blsi_prod #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (setup_valid),
        .o_ready (prod_ready),
        .i_early (setup_early),
        .i_t1    (t1),
        .i_t2    (t2),
        .i_t3    (t3),
        .i_t4    (t4),
        .i_xl    (xl),
        .i_yl    (yl),
        .i_ready (out_ready),
        .o_valid (prod_valid),
        .o_early (prod_early),
        .o_p1    (p1),
        .o_p2    (p2),
        .o_p3    (p3),
        .o_p4    (p4)
    );

    // The segment crosses the box when it enters on one axis before it
    // leaves on the other, in both orders.
    assign n_hit = prod_early.done ? prod_early.hit : ((p1 < p2) && (p3 < p4));

    assign out_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_valid && out_ready) begin
            r_hit <= n_hit;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.hits_box = r_hit;

endmodule

// File: tb/box_line_segment_intersect_test.sv
// ----------------------------------------------------------------------------
// box_line_segment_intersect_test
// Self-checking bench for the box / line-segment intersection block. A short
// table of hand-picked geometries is followed by random boxes and segments.
// Every item is scored against the answer written in its table row or against a
// predictor with exact wide arithmetic, while both handshake sides stall at random.
// ----------------------------------------------------------------------------
module box_line_segment_intersect_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_WIDTH = blsi_pkg::COORD_WIDTH_DEF;
    localparam int ONE = 256;  // 1.0 in 24.8 fixed point
    localparam logic signed [COORD_WIDTH-1:0] CMIN = 32'sh8000_0000;
    localparam logic signed [COORD_WIDTH-1:0] CMAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_DIRECTED = 22;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_left;
        logic signed [COORD_WIDTH-1:0] box_top;
        logic signed [COORD_WIDTH-1:0] box_right;
        logic signed [COORD_WIDTH-1:0] box_bottom;
        logic signed [COORD_WIDTH-1:0] seg_start_x;
        logic signed [COORD_WIDTH-1:0] seg_start_y;
        logic signed [COORD_WIDTH-1:0] seg_end_x;
        logic signed [COORD_WIDTH-1:0] seg_end_y;
    } t_seg_box;

    typedef struct packed {
        t_seg_box geo;
        logic     typed;  // answer is written in the row
        logic     want;
    } t_dir_row;

    typedef struct {
        int idx;
        bit hit;
    } t_hit_expect;

    // Box 0..10 on both axes unless a row says otherwise.
    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        '{'{0, 0, 10*ONE, 10*ONE, 5*ONE, 5*ONE, 100*ONE, 100*ONE}, 1'b1, 1'b1},
        '{'{0, 0, 10*ONE, 10*ONE, -100*ONE, -100*ONE, 5*ONE, 5*ONE}, 1'b1, 1'b1},
        '{'{0, 0, 10*ONE, 10*ONE, -5*ONE, -3*ONE, 15*ONE, 13*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, -5*ONE, 8*ONE, 3*ONE, 20*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, -5*ONE, 5*ONE, 15*ONE, 5*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, -5*ONE, 20*ONE, 15*ONE, 20*ONE}, 1'b1, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, 5*ONE, -5*ONE, 5*ONE, 15*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, -3*ONE, -5*ONE, -3*ONE, 15*ONE}, 1'b1, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, 20*ONE, 20*ONE, 20*ONE, 20*ONE}, 1'b1, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE}, 1'b1, 1'b1},
        '{'{10*ONE, 0, 0, 10*ONE, -5*ONE, 5*ONE, 15*ONE, 5*ONE}, 1'b0, 1'b0},
        '{'{10*ONE, 10*ONE, 0, 0, 5*ONE, 5*ONE, 5*ONE, 5*ONE}, 1'b1, 1'b0},
        '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b1, 1'b1},
        '{'{0, 0, 0, 0, CMIN, CMIN, CMAX, CMAX}, 1'b0, 1'b0},
        '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b1, 1'b1},
        '{'{CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX}, 1'b1, 1'b0},
        '{'{-ONE, -ONE, ONE, ONE, CMAX, CMIN, CMIN, CMAX}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, 5*ONE, 15*ONE, 15*ONE, 5*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, 15*ONE, 13*ONE, -5*ONE, -3*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 10*ONE, 10*ONE, 10*ONE, 5*ONE, 20*ONE, 5*ONE}, 1'b1, 1'b1},
        '{'{0, 0, 10*ONE, 10*ONE, 5*ONE, 16*ONE, 16*ONE, 5*ONE}, 1'b0, 1'b0},
        '{'{0, 0, 1, 1, -1, 2, 2, -1}, 1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    blsi_in_if #(.COORD_WIDTH(COORD_WIDTH)) in_ch ();
    blsi_out_if out_ch ();

    box_line_segment_intersect #(.COORD_WIDTH(COORD_WIDTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_hit_expect hit_expect_q[$];
    int items_sent = 0;
    int hit_count = 0;
    int miss_count = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_seq = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // a*b < c*d, exact: operands fit in 34 bits, so 70 bits cannot wrap.
    function automatic bit product_below(longint a, longint b, longint c, longint d);
        logic signed [69:0] wa, wb, wc, wd;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        return (wa * wb) < (wc * wd);
    endfunction

    function automatic bit predict_hit(t_seg_box g);
        longint bx0, by0, bx1, by1, ax, ay, ex, ey;
        longint dx, dy, t1, t2, t3, t4;
        bx0 = g.box_left;
        by0 = g.box_top;
        bx1 = g.box_right;
        by1 = g.box_bottom;
        ax = g.seg_start_x;
        ay = g.seg_start_y;
        ex = g.seg_end_x;
        ey = g.seg_end_y;
        t1 = 0;
        t2 = 0;
        t3 = 0;
        t4 = 0;
        if ((ax >= bx0 && ax <= bx1 && ay >= by0 && ay <= by1) ||
            (ex >= bx0 && ex <= bx1 && ey >= by0 && ey <= by1))
            return 1'b1;
        dx = ex - ax;
        dy = ey - ay;

        // Distances to the edges are measured along the direction of travel.
        if (dx > 0) begin
            t1 = bx0 - ax;
            t2 = bx1 - ax;
        end else if (dx < 0) begin
            t1 = ax - bx1;
            t2 = ax - bx0;
            dx = -dx;
        end else if (ax < bx0 || ax > bx1) begin
            return 1'b0;
        end
        if (dx != 0 && (t1 < 0 || t1 > dx) && (t2 < 0 || t2 > dx))
            return 1'b0;

        if (dy > 0) begin
            t3 = by0 - ay;
            t4 = by1 - ay;
        end else if (dy < 0) begin
            t3 = ay - by1;
            t4 = ay - by0;
            dy = -dy;
        end else if (ay < by0 || ay > by1) begin
            return 1'b0;
        end
        if (dy != 0 && (t3 < 0 || t3 > dy) && (t4 < 0 || t4 > dy))
            return 1'b0;

        if (dx == 0 || dy == 0)
            return 1'b1;
        return product_below(t1, dy, t4, dx) && product_below(t3, dx, t2, dy);
    endfunction

    function automatic int offset(int reach, int sc);
        return (int'($urandom_range(2 * reach)) - reach) * sc;
    endfunction

    // Mostly boxes and segments at the same place and scale, so that edges
    // coincide often; some fully random items and some at the range limits.
    function automatic t_seg_box random_geometry();
        t_seg_box g;
        int shape, sc;
        logic signed [COORD_WIDTH-1:0] cx, cy, swap;
        shape = $urandom_range(99);
        cx = $urandom;
        cy = $urandom;
        sc = ($urandom_range(99) < 60) ? int'($urandom_range(1, 2 * ONE))
                                       : int'($urandom_range(1, 1 << 22));
        g.box_left = cx - int'($urandom_range(10)) * sc;
        g.box_right = cx + int'($urandom_range(10)) * sc;
        g.box_top = cy - int'($urandom_range(10)) * sc;
        g.box_bottom = cy + int'($urandom_range(10)) * sc;
        g.seg_start_x = cx + offset(20, sc);
        g.seg_start_y = cy + offset(20, sc);
        g.seg_end_x = cx + offset(20, sc);
        g.seg_end_y = cy + offset(20, sc);
        if (shape < 8) begin
            g = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end else if (shape < 16) begin
            swap = g.box_left;
            g.box_left = g.box_right;
            g.box_right = swap;
            if ($urandom_range(1)) begin
                swap = g.box_top;
                g.box_top = g.box_bottom;
                g.box_bottom = swap;
            end
        end else if (shape < 28) begin
            g.seg_end_y = g.seg_start_y;
        end else if (shape < 40) begin
            g.seg_end_x = g.seg_start_x;
        end else if (shape < 46) begin
            g.seg_end_x = g.seg_start_x;
            g.seg_end_y = g.seg_start_y;
        end else if (shape < 54) begin
            if ($urandom_range(1)) g.box_left = CMIN;
            if ($urandom_range(1)) g.box_bottom = CMAX;
            if ($urandom_range(1)) g.seg_start_x = $urandom_range(1) ? CMIN : CMAX;
            if ($urandom_range(1)) g.seg_end_y = $urandom_range(1) ? CMIN : CMAX;
            if ($urandom_range(1)) g.seg_end_x = $urandom_range(1) ? CMIN : CMAX;
        end
        return g;
    endfunction

    task automatic offer_item(input t_seg_box g, input bit typed, input bit want);
        t_hit_expect e;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.box_left <= g.box_left;
        in_ch.box_top <= g.box_top;
        in_ch.box_right <= g.box_right;
        in_ch.box_bottom <= g.box_bottom;
        in_ch.seg_start_x <= g.seg_start_x;
        in_ch.seg_start_y <= g.seg_start_y;
        in_ch.seg_end_x <= g.seg_end_x;
        in_ch.seg_end_y <= g.seg_end_y;
        do @(posedge i_clk); while (!in_ch.ready);
        e.idx = items_sent;
        e.hit = typed ? want : predict_hit(g);
        hit_expect_q.push_back(e);
        items_sent++;
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (hit_expect_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int ph, n, r;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.box_left <= '0;
        in_ch.box_top <= '0;
        in_ch.box_right <= '0;
        in_ch.box_bottom <= '0;
        in_ch.seg_start_x <= '0;
        in_ch.seg_start_y <= '0;
        in_ch.seg_end_x <= '0;
        in_ch.seg_end_y <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 46 : 0;
            sink_idle_pct <= (ph == 0) ? 46 : (ph == 1) ? 12 : 0;
            if (ph == 0) begin
                for (r = 0; r < NUM_DIRECTED; r++)
                    offer_item(DIRECTED[r].geo, DIRECTED[r].typed, DIRECTED[r].want);
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                // The output holds off for a while; the pipeline fills and
                // must stall the input without losing an item.
                if (ph == 0 && n == 60)
                    hold_seq <= hold_seq + 1;
                offer_item(random_geometry(), 1'b0, 1'b0);
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d items (%0d from the table): %0d hits, %0d misses.",
                 items_sent, NUM_DIRECTED, hit_count, miss_count);
        $display("Covered random stalls on both sides, a long output hold and drains.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d check(s) failed", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_checker
        int stall_left, hold_seen;
        t_hit_expect e;
        stall_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (hit_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: hits_box %0b with nothing pending",
                                 out_ch.hits_box);
                end else begin
                    e = hit_expect_q.pop_front();
                    if (out_ch.hits_box !== e.hit) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("item %0d: hits_box expected %0b, got %0b",
                                     e.idx, e.hit, out_ch.hits_box);
                    end
                    if (e.hit) hit_count++;
                    else miss_count++;
                end
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                stall_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, hit_expect_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: box_line_segment_intersect.f
src/blsi_pkg.sv
src/blsi_if.sv
src/blsi_setup.sv
src/blsi_prod.sv
src/box_line_segment_intersect.sv
tb/box_line_segment_intersect_test.sv
